### hdl/clns_pkg.sv
// Shared types and constants for the character LCD nibble sequencer.
// No dependencies; imported by the controller, datapath, top level and checker.
package clns_pkg;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] INIT_LAST_STEP = STEP_W'(11);
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP = STEP_W'(1);

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_CURSOR = 2'd1,
        OP_CHAR   = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        CFG_TWO_LINES  = 3'd0,
        CFG_BIG_FONT   = 3'd1,
        CFG_DISPLAY_ON = 3'd2,
        CFG_CURSOR_ON  = 3'd3,
        CFG_BLINK_ON   = 3'd4,
        CFG_ENTRY_INC  = 3'd5,
        CFG_ENTRY_SHFT = 3'd6
    } t_cfg_idx;

    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;

    localparam logic [7:0] CMD_FSET  = 8'h20;
    localparam logic [7:0] CMD_DCTL  = 8'h08;
    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_EMODE = 8'h04;
    localparam logic [7:0] CMD_ADDR  = 8'h80;

    localparam logic [15:0] WAIT_POWER_UP = 16'd50000;
    localparam logic [12:0] WAIT_WAKE_1   = 13'd4200;
    localparam logic [12:0] WAIT_WAKE_2   = 13'd150;
    localparam logic [12:0] WAIT_DCTL     = 13'd2000;

    // controller -> datapath
    typedef struct packed {
        logic              load;
        logic [STEP_W-1:0] step;
    } t_ctl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op_valid;
        logic last;
    } t_dp_status;

endpackage

### hdl/clns_ctrl.sv
// Sequencing controller: handshakes and nibble step counter.
// Depends on clns_pkg.
module clns_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output clns_pkg::t_ctl_cmd    o_cmd,
    input  clns_pkg::t_dp_status  i_status
);
    import clns_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic              r_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_in_stall  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    // an unused opcode is taken and dropped
                    if (i_in_valid && i_status.op_valid) begin
                        r_state     <= ST_SEND;
                        r_step      <= '0;
                        r_out_valid <= 1'b1;
                        r_in_stall  <= 1'b1;
                    end
                end
                ST_SEND: begin
                    if (!i_out_stall) begin
                        if (i_status.last) begin
                            r_state     <= ST_IDLE;
                            r_out_valid <= 1'b0;
                            r_in_stall  <= 1'b0;
                        end else begin
                            r_step <= r_step + STEP_W'(1);
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_cmd.load  = i_in_valid && (r_state == ST_IDLE);
    assign o_cmd.step  = r_step;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = r_in_stall;

endmodule

### hdl/clns_datapath.sv
// Datapath: config bits, latched request and nibble/wait generation per step.
// Depends on clns_pkg.
module clns_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr,
    input  logic [2:0]            i_cfg_index,
    input  logic                  i_cfg_data,
    input  logic [1:0]            i_opcode,
    input  logic                  i_row,
    input  logic [5:0]            i_col,
    input  logic [7:0]            i_char_code,
    input  clns_pkg::t_ctl_cmd    i_cmd,
    output clns_pkg::t_dp_status  o_status,
    output logic                  o_rs_data,
    output logic [3:0]            o_nibble,
    output logic [15:0]           o_wait_before_us,
    output logic [12:0]           o_wait_after_us
);
    import clns_pkg::*;

    logic r_two_lines, r_big_font, r_display_on, r_cursor_on;
    logic r_blink_on, r_entry_inc, r_entry_shft;

    t_opcode    r_op;
    logic [7:0] r_byte;    // address command or character, built at load

    logic [7:0] n_byte;
    logic [7:0] cur_byte;
    logic [6:0] addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_lines  <= 1'b1;
            r_big_font   <= 1'b0;
            r_display_on <= 1'b1;
            r_cursor_on  <= 1'b0;
            r_blink_on   <= 1'b0;
            r_entry_inc  <= 1'b1;
            r_entry_shft <= 1'b0;
        end else if (i_cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TWO_LINES:  r_two_lines  <= i_cfg_data;
                CFG_BIG_FONT:   r_big_font   <= i_cfg_data;
                CFG_DISPLAY_ON: r_display_on <= i_cfg_data;
                CFG_CURSOR_ON:  r_cursor_on  <= i_cfg_data;
                CFG_BLINK_ON:   r_blink_on   <= i_cfg_data;
                CFG_ENTRY_INC:  r_entry_inc  <= i_cfg_data;
                CFG_ENTRY_SHFT: r_entry_shft <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign addr   = r_two_lines ? {i_row, i_col} : {1'b0, i_col};
    assign n_byte = (t_opcode'(i_opcode) == OP_CURSOR) ? (CMD_ADDR | {1'b0, addr})
                                                       : i_char_code;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_opcode'(i_opcode);
            r_byte <= n_byte;
        end
    end

    assign o_status.op_valid = (t_opcode'(i_opcode) != OP_NONE);
    assign o_status.last     = (r_op == OP_INIT) ? (i_cmd.step == INIT_LAST_STEP)
                                                 : (i_cmd.step == BYTE_LAST_STEP);

    // init command bytes follow the four wake-up nibbles, two steps each
    always_comb begin
        cur_byte = r_byte;
        if (r_op == OP_INIT) begin
            case (i_cmd.step[3:1])
                3'd2:    cur_byte = CMD_FSET | {4'b0, r_two_lines, r_big_font, 2'b0};
                3'd3:    cur_byte = CMD_DCTL | {5'b0, r_display_on, r_cursor_on, r_blink_on};
                3'd4:    cur_byte = CMD_CLEAR;
                default: cur_byte = CMD_EMODE | {6'b0, r_entry_inc, r_entry_shft};
            endcase
        end
    end

    always_comb begin
        o_rs_data        = (r_op == OP_CHAR);
        o_nibble         = i_cmd.step[0] ? cur_byte[3:0] : cur_byte[7:4];
        o_wait_before_us = '0;
        o_wait_after_us  = '0;
        if (r_op == OP_INIT) begin
            case (i_cmd.step)
                STEP_W'(0): begin
                    o_nibble         = NIB_WAKE;
                    o_wait_before_us = WAIT_POWER_UP;
                    o_wait_after_us  = WAIT_WAKE_1;
                end
                STEP_W'(1): begin
                    o_nibble        = NIB_WAKE;
                    o_wait_after_us = WAIT_WAKE_2;
                end
                STEP_W'(2): o_nibble = NIB_WAKE;
                STEP_W'(3): o_nibble = NIB_4BIT;
                STEP_W'(7): o_wait_after_us = WAIT_DCTL;
                default: ;
            endcase
        end
    end

endmodule

### hdl/char_lcd_nibble_sequencer.sv
// Character LCD nibble sequencer, 4-bit bus: turns requests into nibble beats.
// The first nibble is valid in the cycle after the request beat is taken.
// Throughput: one nibble per cycle without back-pressure; init is 12 beats,
// set-cursor and write-char 2, and a new request is stalled until the last
// beat is sent. An unused opcode is taken and gives nothing.
// Reset (synchronous, active low) idles the block and loads default config.
module char_lcd_nibble_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic        i_row,
    input  logic [5:0]  i_col,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_rs_data,
    output logic [3:0]  o_nibble,
    output logic [15:0] o_wait_before_us,
    output logic [12:0] o_wait_after_us,
    output logic        o_last
);
    import clns_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;
    assign o_last      = status.last;

    clns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    clns_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_char_code      (i_char_code),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_rs_data        (o_rs_data),
        .o_nibble         (o_nibble),
        .o_wait_before_us (o_wait_before_us),
        .o_wait_after_us  (o_wait_after_us)
    );

endmodule

### hdl/clns_checker.sv
// Port-level checks for the nibble sequencer, bound to the top level.
// Depends on clns_pkg; sees char_lcd_nibble_sequencer only through its ports.
module clns_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_opcode,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_rs_data,
    input logic [3:0]  o_nibble,
    input logic [15:0] o_wait_before_us,
    input logic [12:0] o_wait_after_us,
    input logic        o_last
);
    import clns_pkg::*;

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_nibble) &&
        $stable(o_rs_data) && $stable(o_last))
        else $error("stalled output beat changed");

    // one request at a time
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while nibbles pending");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_opcode != OP_NONE |=> o_out_valid)
        else $error("request taken but no nibble followed");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_last |=> !o_out_valid)
        else $error("beat after final nibble");

    a_data_nowait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rs_data |-> o_wait_before_us == 16'd0 &&
        o_wait_after_us == 13'd0)
        else $error("data nibble carries extra wait");

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_opcode         (i_opcode),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_rs_data        (o_rs_data),
    .o_nibble         (o_nibble),
    .o_wait_before_us (o_wait_before_us),
    .o_wait_after_us  (o_wait_after_us),
    .o_last           (o_last)
);
